>>> sv/vdil6_pkg.sv
// Shared types, constants and helpers for the 6-connected volume dilation block.
// No dependencies; every other file but vdil6_ram refers to it by scoped names.
package vdil6_pkg;

    // Volume limits and payload width
    localparam int MAX_X      = 256;
    localparam int MAX_Y      = 256;
    localparam int VALUE_BITS = 16;

    // Derived widths
    localparam int X_BITS     = $clog2(MAX_X);
    localparam int Y_BITS     = $clog2(MAX_Y);
    localparam int SLICE_BITS = X_BITS + Y_BITS;
    localparam int EX_BITS    = X_BITS + 1;
    localparam int EY_BITS    = Y_BITS + 1;

    // Configuration register widths and port
    localparam int SIZE_XY_BITS = 9;
    localparam int Z_BITS       = 16;
    localparam int CFG_BITS     = 16;
    localparam int IDX_BITS     = 2;

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_SIZE_Z = 2'd2;

    // Reset values of the size registers
    localparam logic [SIZE_XY_BITS-1:0] RST_SIZE_X = 9'd256;
    localparam logic [SIZE_XY_BITS-1:0] RST_SIZE_Y = 9'd256;
    localparam logic [Z_BITS-1:0]       RST_SIZE_Z = 16'd1;

    // Queue depths
    localparam int QDEPTH = 2;
    localparam int ODEPTH = 4;

    // Volume geometry derived from the size registers
    typedef struct packed {
        logic [X_BITS-1:0]     xm1;      // last x index
        logic [Y_BITS-1:0]     ym1;      // last y index
        logic [Z_BITS-1:0]     zm1;      // last z index
        logic [SLICE_BITS-1:0] d_slice;  // slice - 1
        logic [SLICE_BITS-1:0] d_psx;    // slice - size_x
        logic [X_BITS-1:0]     d_msx;    // size_x - 1
    } geo_t;

    // Per-result boundary flags and end marker
    typedef struct packed {
        logic last;
        logic xp;
        logic xm;
        logic yp;
        logic ym;
        logic zp;
        logic zm;
    } meta_t;

    // Command from front to back: shift one value into the window
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  emit;
        meta_t                 meta;
    } cmd_t;

    // Front state machine
    typedef enum logic [1:0] {
        FE_RUN   = 2'b01,
        FE_EXTRA = 2'b10
    } fe_state_t;

    // Positive: nonzero with the sign bit clear
    function automatic logic is_pos(input logic [VALUE_BITS-1:0] v);
        logic r;
        r = (v != '0) && !v[VALUE_BITS-1];
        return r;
    endfunction

endpackage

>>> sv/volume_dilate_6conn.sv
// Top level of the streaming 6-connected 3D dilation block.
// Depends on vdil6_pkg, vdil6_front, vdil6_queue, vdil6_back.
//
// Usage:
//   Voxels enter on the voxel channel (voxel_valid/voxel_ready) in raster
//   order, x fastest. Results leave on the result channel
//   (result_valid/result_ready) in the same order; last marks the final one.
//   After the last voxel, send one drain transaction per pending result.
//   Sizes are written through cfg_we/cfg_index/cfg_data while idle; a write
//   restarts the volume.
// Path: the result for voxel p is formed from the transaction that carries voxel
//   p + size_x*size_y (or the matching drain), then held in the output queue.
// Throughput: one transaction per cycle while the queues have room; the final
//   voxel of a single-slice volume blocks the input for an extra shift. The
//   rate is set by the window delay RAMs: one write and one read per cycle.
// Reset: sizes return to 256 x 256 x 1 and positions to zero; window RAM
//   contents need no clearing since only voxels of the current volume are read.
// Stall: a stalled receiver fills the four-entry result queue, then the
//   two-entry command queue, after which voxel_ready drops.
module volume_dilate_6conn (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [vdil6_pkg::IDX_BITS-1:0]          cfg_index,
    input  logic [vdil6_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                    voxel_valid,
    output logic                                    voxel_ready,
    input  logic signed [vdil6_pkg::VALUE_BITS-1:0] voxel_value,
    input  logic                                    drain,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [vdil6_pkg::VALUE_BITS-1:0] result_value,
    output logic                                    last
);

    localparam int XYB = vdil6_pkg::SIZE_XY_BITS;
    localparam int EXB = vdil6_pkg::EX_BITS;
    localparam int EYB = vdil6_pkg::EY_BITS;
    localparam int SB  = vdil6_pkg::SLICE_BITS;

    logic [XYB-1:0]               sx_reg, sx_next, sy_reg, sy_next;
    logic [vdil6_pkg::Z_BITS-1:0] sz_reg, sz_next;
    vdil6_pkg::geo_t              geo_reg, geo_next;
    logic                         restart;

    logic [EXB-1:0] ex;
    logic [EYB-1:0] ey;
    logic [SB:0]    slice;

    vdil6_pkg::cmd_t push_cmd, head;
    logic            push, pop, q_full, q_empty;

    // Decode configuration writes
    always_comb
    begin
        sx_next = sx_reg;
        sy_next = sy_reg;
        sz_next = sz_reg;
        restart = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                vdil6_pkg::REG_SIZE_X:
                begin
                    sx_next = cfg_data[XYB-1:0];
                    restart = 1'b1;
                end
                vdil6_pkg::REG_SIZE_Y:
                begin
                    sy_next = cfg_data[XYB-1:0];
                    restart = 1'b1;
                end
                vdil6_pkg::REG_SIZE_Z:
                begin
                    sz_next = cfg_data;
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Clamp sizes and derive the window geometry
    always_comb
    begin
        if (sx_next == '0)
        begin
            ex = EXB'(1);
        end
        else if (int'(sx_next) > vdil6_pkg::MAX_X)
        begin
            ex = EXB'(vdil6_pkg::MAX_X);
        end
        else
        begin
            ex = EXB'(sx_next);
        end

        if (sy_next == '0)
        begin
            ey = EYB'(1);
        end
        else if (int'(sy_next) > vdil6_pkg::MAX_Y)
        begin
            ey = EYB'(vdil6_pkg::MAX_Y);
        end
        else
        begin
            ey = EYB'(sy_next);
        end

        slice            = (SB + 1)'(ex * ey);
        geo_next.xm1     = vdil6_pkg::X_BITS'(ex - 1'b1);
        geo_next.ym1     = vdil6_pkg::Y_BITS'(ey - 1'b1);
        geo_next.zm1     = (sz_next == '0) ? '0 : sz_next - 1'b1;
        geo_next.d_slice = SB'(slice - 1'b1);
        geo_next.d_psx   = SB'(slice - (SB + 1)'(ex));
        geo_next.d_msx   = vdil6_pkg::X_BITS'(ex - 1'b1);
    end

    // Configuration and geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg           <= vdil6_pkg::RST_SIZE_X;
            sy_reg           <= vdil6_pkg::RST_SIZE_Y;
            sz_reg           <= vdil6_pkg::RST_SIZE_Z;
            geo_reg.xm1      <= vdil6_pkg::X_BITS'(vdil6_pkg::MAX_X - 1);
            geo_reg.ym1      <= vdil6_pkg::Y_BITS'(vdil6_pkg::MAX_Y - 1);
            geo_reg.zm1      <= '0;
            geo_reg.d_slice  <= SB'(vdil6_pkg::MAX_X * vdil6_pkg::MAX_Y - 1);
            geo_reg.d_psx    <= SB'(vdil6_pkg::MAX_X * vdil6_pkg::MAX_Y - vdil6_pkg::MAX_X);
            geo_reg.d_msx    <= vdil6_pkg::X_BITS'(vdil6_pkg::MAX_X - 1);
        end
        else
        begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            geo_reg <= geo_next;
        end
    end

    vdil6_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .geo         (geo_reg),
        .voxel_valid (voxel_valid),
        .voxel_ready (voxel_ready),
        .voxel_value (voxel_value),
        .drain       (drain),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    vdil6_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    vdil6_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .geo          (geo_reg),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_value (result_value),
        .last         (last)
    );

endmodule

>>> sv/vdil6_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module vdil6_ram #(
    parameter int WIDTH     = 1,
    parameter int ADDR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_BITS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/vdil6_front.sv
// Front end: accepts voxel and drain transactions, tracks input and output
// positions, and issues shift commands. Depends on vdil6_pkg.
module vdil6_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                restart,
    input  vdil6_pkg::geo_t                     geo,
    input  logic                                voxel_valid,
    output logic                                voxel_ready,
    input  logic signed [vdil6_pkg::VALUE_BITS-1:0] voxel_value,
    input  logic                                drain,
    input  logic                                q_full,
    output logic                                push,
    output vdil6_pkg::cmd_t                     cmd
);

    vdil6_pkg::fe_state_t state_reg, state_next;

    logic [vdil6_pkg::X_BITS-1:0] ix_reg, ix_next, ox_reg, ox_next;
    logic [vdil6_pkg::Y_BITS-1:0] iy_reg, iy_next, oy_reg, oy_next;
    logic [vdil6_pkg::Z_BITS-1:0] iz_reg, iz_next, oz_reg, oz_next;
    logic                         done_reg, done_next;

    logic accept, is_voxel, last_in, last_out, emit;

    // Classify the transaction and build the command
    always_comb
    begin
        voxel_ready = (state_reg == vdil6_pkg::FE_RUN) && !q_full;
        accept      = voxel_valid && voxel_ready;
        is_voxel    = !drain && !done_reg;
        last_in     = (ix_reg == geo.xm1) && (iy_reg == geo.ym1) && (iz_reg == geo.zm1);
        last_out    = (ox_reg == geo.xm1) && (oy_reg == geo.ym1) && (oz_reg == geo.zm1);

        push       = 1'b0;
        emit       = 1'b0;
        state_next = state_reg;

        case (state_reg)
            vdil6_pkg::FE_RUN:
            begin
                if (accept)
                begin
                    if (is_voxel)
                    begin
                        push = 1'b1;
                        if (last_in && (iz_reg == '0))
                        begin
                            // single slice: one more shift lines up the first result
                            state_next = vdil6_pkg::FE_EXTRA;
                        end
                        else
                        begin
                            emit = (iz_reg != '0) || last_in;
                        end
                    end
                    else if (done_reg)
                    begin
                        push = 1'b1;
                        emit = 1'b1;
                    end
                end
            end
            vdil6_pkg::FE_EXTRA:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    emit       = 1'b1;
                    state_next = vdil6_pkg::FE_RUN;
                end
            end
            default:
            begin
                state_next = vdil6_pkg::FE_RUN;
            end
        endcase

        cmd.value   = (state_reg == vdil6_pkg::FE_RUN && is_voxel) ? voxel_value : '0;
        cmd.emit    = emit;
        cmd.meta.last = last_out;
        cmd.meta.xp = (ox_reg != geo.xm1);
        cmd.meta.xm = (ox_reg != '0);
        cmd.meta.yp = (oy_reg != geo.ym1);
        cmd.meta.ym = (oy_reg != '0);
        cmd.meta.zp = (oz_reg != geo.zm1);
        cmd.meta.zm = (oz_reg != '0);
    end

    // Advance input and output positions
    always_comb
    begin
        ix_next   = ix_reg;
        iy_next   = iy_reg;
        iz_next   = iz_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        oz_next   = oz_reg;
        done_next = done_reg;

        if (accept && is_voxel)
        begin
            if (last_in)
            begin
                done_next = 1'b1;
            end
            else if (ix_reg != geo.xm1)
            begin
                ix_next = ix_reg + 1'b1;
            end
            else
            begin
                ix_next = '0;
                if (iy_reg != geo.ym1)
                begin
                    iy_next = iy_reg + 1'b1;
                end
                else
                begin
                    iy_next = '0;
                    iz_next = iz_reg + 1'b1;
                end
            end
        end

        if (push && emit)
        begin
            if (last_out)
            begin
                // volume complete: start over
                ix_next   = '0;
                iy_next   = '0;
                iz_next   = '0;
                ox_next   = '0;
                oy_next   = '0;
                oz_next   = '0;
                done_next = 1'b0;
            end
            else if (ox_reg != geo.xm1)
            begin
                ox_next = ox_reg + 1'b1;
            end
            else
            begin
                ox_next = '0;
                if (oy_reg != geo.ym1)
                begin
                    oy_next = oy_reg + 1'b1;
                end
                else
                begin
                    oy_next = '0;
                    oz_next = oz_reg + 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdil6_pkg::FE_RUN;
            ix_reg    <= '0;
            iy_reg    <= '0;
            iz_reg    <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            oz_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else if (restart)
        begin
            state_reg <= vdil6_pkg::FE_RUN;
            ix_reg    <= '0;
            iy_reg    <= '0;
            iz_reg    <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            oz_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ix_reg    <= ix_next;
            iy_reg    <= iy_next;
            iz_reg    <= iz_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            oz_reg    <= oz_next;
            done_reg  <= done_next;
        end
    end

endmodule

>>> sv/vdil6_queue.sv
// Short command queue between front and back.
// Depends on vdil6_pkg for cmd_t and QDEPTH.
module vdil6_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vdil6_pkg::cmd_t push_cmd,
    input  logic            pop,
    output vdil6_pkg::cmd_t head,
    output logic            full,
    output logic            empty
);

    localparam int PB = $clog2(vdil6_pkg::QDEPTH);
    localparam int CB = $clog2(vdil6_pkg::QDEPTH + 1);

    vdil6_pkg::cmd_t entry_reg [vdil6_pkg::QDEPTH];
    logic [PB-1:0]   wp_reg, rp_reg;
    logic [CB-1:0]   count_reg;

    assign full  = (count_reg == CB'(vdil6_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rp_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PB'(vdil6_pkg::QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PB'(vdil6_pkg::QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            count_reg <= count_reg + CB'(push) - CB'(pop);
        end
    end

endmodule

>>> sv/vdil6_back.sv
// Back end: shifts values through the neighborhood window (delay RAMs and
// taps), forms each result and holds it in the output queue.
// Depends on vdil6_pkg and vdil6_ram.
module vdil6_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  vdil6_pkg::geo_t                         geo,
    input  vdil6_pkg::cmd_t                         head,
    input  logic                                    q_empty,
    output logic                                    pop,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [vdil6_pkg::VALUE_BITS-1:0] result_value,
    output logic                                    last
);

    localparam int VB  = vdil6_pkg::VALUE_BITS;
    localparam int SB  = vdil6_pkg::SLICE_BITS;
    localparam int XB  = vdil6_pkg::X_BITS;
    localparam int OPB = $clog2(vdil6_pkg::ODEPTH);
    localparam int OCB = $clog2(vdil6_pkg::ODEPTH + 1);

    logic [SB-1:0] wp_reg;
    logic [VB-1:0] c1_reg;          // center value
    logic          c0_reg;          // x - 1 neighbor
    logic          n0_reg;          // z + 1 neighbor
    logic [VB-1:0] byp_val_reg;
    logic          byp_new_reg;
    logic          byp_c1_reg;
    vdil6_pkg::meta_t meta_reg;
    logic          pend_reg;

    logic [VB-1:0] rd_c2;
    logic          rd_psx, rd_msx, rd_msl;
    logic [VB-1:0] t_c2;
    logic          t_psx, t_msx, t_msl;
    logic          new_pos, c1_pos, hit;
    logic [VB-1:0] res;

    logic [VB-1:0]  oval_reg [vdil6_pkg::ODEPTH];
    logic           olast_reg [vdil6_pkg::ODEPTH];
    logic [OPB-1:0] owp_reg, orp_reg;
    logic [OCB-1:0] ocount_reg;
    logic [OCB:0]   committed;
    logic           opop;

    // Issue a shift only while the output queue has room for its result
    assign committed = {1'b0, ocount_reg} + (OCB + 1)'(pend_reg);
    assign pop       = !q_empty && (committed < (OCB + 1)'(vdil6_pkg::ODEPTH));
    assign new_pos   = vdil6_pkg::is_pos(head.value);
    assign c1_pos    = vdil6_pkg::is_pos(c1_reg);

    // Delay line to x + 1 (feeds the center)
    vdil6_ram #(.WIDTH(VB), .ADDR_BITS(SB)) u_ram_c2 (
        .clk   (clk),
        .we    (pop),
        .waddr (wp_reg),
        .wdata (head.value),
        .re    (pop),
        .raddr (wp_reg - geo.d_slice),
        .rdata (rd_c2)
    );

    // Delay line to y + 1
    vdil6_ram #(.WIDTH(1), .ADDR_BITS(SB)) u_ram_psx (
        .clk   (clk),
        .we    (pop),
        .waddr (wp_reg),
        .wdata (new_pos),
        .re    (pop),
        .raddr (wp_reg - geo.d_psx),
        .rdata (rd_psx)
    );

    // Delay line from x - 1 to y - 1
    vdil6_ram #(.WIDTH(1), .ADDR_BITS(XB)) u_ram_msx (
        .clk   (clk),
        .we    (pop),
        .waddr (wp_reg[XB-1:0]),
        .wdata (c1_pos),
        .re    (pop),
        .raddr (wp_reg[XB-1:0] - geo.d_msx),
        .rdata (rd_msx)
    );

    // Delay line from x - 1 to z - 1
    vdil6_ram #(.WIDTH(1), .ADDR_BITS(SB)) u_ram_msl (
        .clk   (clk),
        .we    (pop),
        .waddr (wp_reg),
        .wdata (c1_pos),
        .re    (pop),
        .raddr (wp_reg - geo.d_slice),
        .rdata (rd_msl)
    );

    // Zero-length delays take the bypass registers
    assign t_c2  = (geo.d_slice == '0) ? byp_val_reg : rd_c2;
    assign t_psx = (geo.d_psx == '0)   ? byp_new_reg : rd_psx;
    assign t_msx = (geo.d_msx == '0)   ? byp_c1_reg  : rd_msx;
    assign t_msl = (geo.d_slice == '0) ? byp_c1_reg  : rd_msl;

    // Shift the window taps
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            c1_reg      <= t_c2;
            c0_reg      <= c1_pos;
            n0_reg      <= new_pos;
            byp_val_reg <= head.value;
            byp_new_reg <= new_pos;
            byp_c1_reg  <= c1_pos;
            meta_reg    <= head.meta;
        end
    end

    // Combine the center with its six neighbors
    always_comb
    begin
        hit = (meta_reg.xp && vdil6_pkg::is_pos(t_c2)) ||
              (meta_reg.xm && c0_reg) ||
              (meta_reg.yp && t_psx) ||
              (meta_reg.ym && t_msx) ||
              (meta_reg.zp && n0_reg) ||
              (meta_reg.zm && t_msl);
        res = (c1_reg != '0) ? c1_reg : VB'(hit);
    end

    // Output queue storage
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            oval_reg[owp_reg]  <= res;
            olast_reg[owp_reg] <= meta_reg.last;
        end
    end

    assign result_valid = (ocount_reg != '0);
    assign result_value = oval_reg[orp_reg];
    assign last         = olast_reg[orp_reg];
    assign opop         = result_valid && result_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            pend_reg   <= 1'b0;
            owp_reg    <= '0;
            orp_reg    <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            pend_reg <= pop && head.emit;
            if (pend_reg)
            begin
                owp_reg <= (owp_reg == OPB'(vdil6_pkg::ODEPTH - 1)) ? '0 : owp_reg + 1'b1;
            end
            if (opop)
            begin
                orp_reg <= (orp_reg == OPB'(vdil6_pkg::ODEPTH - 1)) ? '0 : orp_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + OCB'(pend_reg) - OCB'(opop);
        end
    end

endmodule
